// ===== rtl/core/mep_pkg.sv =====
// package for the mandelbrot escape-time pixel engine
// types, fixed-point constants and the colour map used by the mep modules
// no dependencies
package mep_pkg;

    // fixed-point format of coordinates and orbit values
    localparam int FRAC_BITS  = 28;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int Q_DEPTH    = 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_REAL_LEFT  = 3'd0,
        REG_IMAG_LOWER = 3'd1,
        REG_REAL_STEP  = 3'd2,
        REG_IMAG_STEP  = 3'd3,
        REG_MAX_ITER   = 3'd4
    } t_reg_idx;

    // register reset values
    localparam logic signed [31:0] RST_REAL_LEFT  = -32'sd536870912;
    localparam logic signed [31:0] RST_IMAG_LOWER = -32'sd536870912;
    localparam logic [15:0]        RST_MAX_ITER   = 16'd10000;

    // colour constants
    localparam logic [7:0] RED_HIGH   = 8'd240;
    localparam int         SHADE_BIT  = 4;

    // plane geometry seen by the front end
    typedef struct packed {
        logic signed [31:0] real_left;
        logic signed [31:0] imag_lower;
        logic signed [31:0] real_step;
        logic signed [31:0] imag_step;
    } t_plane;

    // point c handed from front to back
    typedef struct packed {
        logic signed [31:0] cy;
        logic signed [31:0] cx;
    } t_point;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_DONE
    } t_back_state;

    // clamp a 64-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // colour of a pixel from its iteration count
    function automatic t_rgb colour(input logic [15:0] count, input logic [15:0] limit);
        t_rgb       c;
        logic [7:0] shade;
        shade = {count[3:0], 4'b0000};
        c     = '0;
        if (count != limit) begin
            if (count[SHADE_BIT]) begin
                c.red   = RED_HIGH;
                c.green = shade;
                c.blue  = shade;
            end else begin
                c.red   = shade;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mep_fifo.sv =====
// short queue of points between the front end and the iteration engine
// registers only, first-word fall-through; depends on nothing
module mep_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/mep_front.sv =====
// front end: clamps pixel indexes and maps them to a point c of the plane
// one multiply stage, then add and saturate on the way into the queue; uses mep_pkg
module mep_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mep_pkg::t_plane i_plane,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [11:0]     i_row,
    input  logic [11:0]     i_col,
    output logic            o_push,
    output mep_pkg::t_point o_point,
    input  logic            i_full
);
    import mep_pkg::*;

    logic               r_busy;
    logic signed [44:0] r_prod_re, r_prod_im;
    logic [11:0]        row_c, col_c;
    logic signed [44:0] n_prod_re, n_prod_im;
    logic signed [63:0] sum_re, sum_im;
    logic               take;

    // clamp indexes to the image
    always_comb begin
        row_c = (32'(i_row) >= MAX_HEIGHT) ? 12'(MAX_HEIGHT - 1) : i_row;
        col_c = (32'(i_col) >= MAX_WIDTH)  ? 12'(MAX_WIDTH - 1)  : i_col;
    end

    // index times step
    assign n_prod_re = 45'($signed({1'b0, col_c})) * 45'(i_plane.real_step);
    assign n_prod_im = 45'($signed({1'b0, row_c})) * 45'(i_plane.imag_step);

    // base plus offset, saturated
    assign sum_re = 64'(i_plane.real_left) + 64'(r_prod_re);
    assign sum_im = 64'(i_plane.imag_lower) + 64'(r_prod_im);
    assign o_point.cx = sat32(sum_re);
    assign o_point.cy = sat32(sum_im);

    assign o_push  = r_busy && !i_full;
    assign o_ready = !r_busy || o_push;
    assign take    = i_valid && o_ready;

    // product stage
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prod_re <= n_prod_re;
            r_prod_im <= n_prod_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
        end else if (o_push) begin
            r_busy <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/mep_back.sv =====
// iteration engine: runs z = z*z + c for one point, then colours the pixel
// each iteration is a multiply step, then an add/saturate/escape-test step; uses mep_pkg
module mep_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_max_iter,
    input  logic            i_q_valid,
    input  mep_pkg::t_point i_point,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_iter,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);
    import mep_pkg::*;

    localparam logic [63:0] ESC_LIMIT = 64'd1 << (2 * FRAC_BITS + 2);

    t_back_state        r_state, n_state;
    logic signed [31:0] r_x, r_y, r_cx, r_cy;
    logic signed [63:0] r_xx, r_yy, r_xy;
    logic [15:0]        r_count;
    logic               r_out_valid;
    logic [15:0]        r_iter;
    t_rgb               r_rgb;

    logic [63:0]        mag;
    logic               stop;
    logic signed [31:0] nx, ny;
    logic               load_out;

    // magnitude of the current z and next z
    assign mag  = 64'(r_xx) + 64'(r_yy);
    assign stop = (mag >= ESC_LIMIT) || (r_count == i_max_iter);
    assign nx   = sat32(((r_xx - r_yy) >>> FRAC_BITS) + 64'(r_cx));
    assign ny   = sat32((r_xy >>> (FRAC_BITS - 1)) + 64'(r_cy));

    // next state and handshakes
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_ADD;
            end
            BK_ADD: begin
                n_state = stop ? BK_DONE : BK_MUL;
            end
            BK_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // orbit datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cx    <= i_point.cx;
            r_cy    <= i_point.cy;
            r_x     <= '0;
            r_y     <= '0;
            r_count <= '0;
        end
        if (r_state == BK_MUL) begin
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_xy <= r_x * r_y;
        end
        if (r_state == BK_ADD && !stop) begin
            r_x     <= nx;
            r_y     <= ny;
            r_count <= r_count + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_iter <= r_count;
            r_rgb  <= colour(r_count, i_max_iter);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_iter  = r_iter;
    assign o_red   = r_rgb.red;
    assign o_green = r_rgb.green;
    assign o_blue  = r_rgb.blue;

endmodule

// ===== rtl/core/mandelbrot_escape_pixel.sv =====
// mandelbrot escape-time pixel engine, top level; uses mep_pkg, mep_front, mep_fifo, mep_back
// path from input transfer to result: front-end product register, point queue, engine states, result register
// the iteration engine works on one point at a time and pops the next only after loading the last result
// the front end and a 2-entry point queue keep taking pixels while the engine iterates
// reset (synchronous, active low) restores the register defaults and empties all stages
module mandelbrot_escape_pixel #(
    parameter int QDEPTH = mep_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // row_index[11:0], col_index[23:12]
    // pixel result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // iter_count[15:0], red[23:16], green[31:24], blue[39:32]
);
    import mep_pkg::*;

    t_plane      r_plane;
    logic [15:0] r_max_iter;
    t_point      front_point, q_point;
    logic        front_push, q_full, q_valid, q_pop;
    logic [15:0] res_iter;
    logic [7:0]  res_red, res_green, res_blue;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.real_left  <= RST_REAL_LEFT;
            r_plane.imag_lower <= RST_IMAG_LOWER;
            r_plane.real_step  <= '0;
            r_plane.imag_step  <= '0;
            r_max_iter         <= RST_MAX_ITER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REAL_LEFT:  r_plane.real_left  <= i_cfg_data;
                REG_IMAG_LOWER: r_plane.imag_lower <= i_cfg_data;
                REG_REAL_STEP:  r_plane.real_step  <= i_cfg_data;
                REG_IMAG_STEP:  r_plane.imag_step  <= i_cfg_data;
                REG_MAX_ITER:   r_max_iter         <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mep_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plane (r_plane),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_row   (s_axis_tdata[11:0]),
        .i_col   (s_axis_tdata[23:12]),
        .o_push  (front_push),
        .o_point (front_point),
        .i_full  (q_full)
    );

    mep_fifo #(
        .WIDTH ($bits(t_point)),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_point),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_point)
    );

    mep_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_iter (r_max_iter),
        .i_q_valid  (q_valid),
        .i_point    (q_point),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_iter     (res_iter),
        .o_red      (res_red),
        .o_green    (res_green),
        .o_blue     (res_blue)
    );

    assign m_axis_tdata = {res_blue, res_green, res_red, res_iter};

endmodule

// ===== verif/mandelbrot_escape_pixel_chk.sv =====
// scoreboard for the mandelbrot escape-time pixel engine
// mirrors the plane registers, predicts count and colour per pixel, compares each result
// depends on mep_pkg for the register indexes, FRAC_BITS and the colour layout
module mandelbrot_escape_pixel_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration channel as seen at the block
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // pixel channel: row_index[11:0], col_index[23:12]
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    input  logic [23:0] i_pix_data,
    // result channel: iter_count[15:0], red[23:16], green[31:24], blue[39:32]
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_longest
);
    timeunit 1ns;
    timeprecision 1ps;
    import mep_pkg::*;

    // one pixel result as it sits on the result bus
    typedef struct packed {
        t_rgb        shade;
        logic [15:0] iters;
    } t_pixel_res;

    // local copy of the plane registers
    logic signed [31:0] plane_left;
    logic signed [31:0] plane_lower;
    logic signed [31:0] plane_re_step;
    logic signed [31:0] plane_im_step;
    logic [15:0]        orbit_limit;

    t_pixel_res pending_pixels[$];
    int         fail_tally;
    int         checked_tally;
    int         longest_orbit;

    // clamp to the signed 32-bit range, kept at 64 bits for further math
    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // escape-time count and colour of one pixel under the current plane
    function automatic t_pixel_res escape_pixel(input logic [11:0] row, input logic [11:0] col);
        logic signed [63:0] base, stride, idx;
        logic signed [63:0] cx, cy, x, y, xx, yy, xy;
        logic [64:0]        mag;
        logic [7:0]         tone;
        int                 n;
        logic               escaped;
        t_pixel_res         p;
        // point c, exact sum then clamp
        base   = plane_left;
        stride = plane_re_step;
        idx    = {52'd0, col};
        cx     = clamp_q(base + idx * stride);
        base   = plane_lower;
        stride = plane_im_step;
        idx    = {52'd0, row};
        cy     = clamp_q(base + idx * stride);
        // orbit of z = z^2 + c with floor rounding
        x       = '0;
        y       = '0;
        n       = 0;
        escaped = 1'b0;
        while (n < orbit_limit && !escaped) begin
            xx  = x * x;
            yy  = y * y;
            xy  = x * y;
            x   = clamp_q(((xx - yy) >>> FRAC_BITS) + cx);
            y   = clamp_q((xy >>> (FRAC_BITS - 1)) + cy);
            mag = 65'(x * x) + 65'(y * y);
            // |z|^2 >= 4 in the squared scale
            escaped = (mag >= (65'd1 << (2 * FRAC_BITS + 2)));
            n++;
        end
        // colour map, black when the limit was reached
        p       = '0;
        p.iters = n[15:0];
        tone    = {n[3:0], 4'b0000};
        if (n != orbit_limit) begin
            if (n[4]) begin
                p.shade.red   = 8'd240;
                p.shade.green = tone;
                p.shade.blue  = tone;
            end else begin
                p.shade.red   = tone;
            end
        end
        return p;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            fail_tally++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // watch all three channels on each edge
    always @(posedge i_clk) begin : scoreboard
        t_pixel_res got;
        t_pixel_res want;
        if (!i_rst_n) begin
            plane_left    = RST_REAL_LEFT;
            plane_lower   = RST_IMAG_LOWER;
            plane_re_step = '0;
            plane_im_step = '0;
            orbit_limit   = RST_MAX_ITER;
            pending_pixels.delete();
        end else begin
            // register writes, unused indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_REAL_LEFT:  plane_left    = i_cfg_data;
                    REG_IMAG_LOWER: plane_lower   = i_cfg_data;
                    REG_REAL_STEP:  plane_re_step = i_cfg_data;
                    REG_IMAG_STEP:  plane_im_step = i_cfg_data;
                    REG_MAX_ITER:   orbit_limit   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // predict on each pixel transfer
            if (i_pix_valid && i_pix_ready) begin
                pending_pixels.push_back(escape_pixel(i_pix_data[11:0], i_pix_data[23:12]));
            end
            // compare each result transfer with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (pending_pixels.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected result, expected none, actual count %0d",
                             $time, got.iters);
                end else begin
                    want = pending_pixels.pop_front();
                    compare_field("iter_count", int'(want.iters), int'(got.iters));
                    compare_field("red", int'(want.shade.red), int'(got.shade.red));
                    compare_field("green", int'(want.shade.green), int'(got.shade.green));
                    compare_field("blue", int'(want.shade.blue), int'(got.shade.blue));
                    checked_tally++;
                    if (int'(want.iters) > longest_orbit) begin
                        longest_orbit = int'(want.iters);
                    end
                end
            end
        end
        o_pending    <= pending_pixels.size();
        o_fail_count <= fail_tally;
        o_checked    <= checked_tally;
        o_longest    <= longest_orbit;
    end

endmodule

// ===== verif/mandelbrot_escape_pixel_tb.sv =====
// top of the mandelbrot escape-time pixel testbench: clock, reset, stimulus and verdict
// depends on mep_pkg, mandelbrot_escape_pixel and mandelbrot_escape_pixel_chk
module mandelbrot_escape_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mep_pkg::*;

    // 1.0 in Q4.28
    localparam int Q_ONE = 268435456;
    // indexes past the register file
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    // cycles without any transfer before the run is called hung
    localparam int STALL_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int longest;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int pixels_sent = 0;
    int reg_writes  = 0;
    int stall_cycles = 0;

    mandelbrot_escape_pixel dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mandelbrot_escape_pixel_chk u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (s_axis_tvalid),
        .i_pix_ready  (s_axis_tready),
        .i_pix_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_longest    (longest)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // hang detection: no transfer on any channel for too long
    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // one register write, valid dropped the cycle after the transfer
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic set_plane(input logic signed [31:0] left, input logic signed [31:0] lower,
                             input logic signed [31:0] re_step,
                             input logic signed [31:0] im_step, input logic [15:0] limit);
        cfg_write(REG_REAL_LEFT, left);
        cfg_write(REG_IMAG_LOWER, lower);
        cfg_write(REG_REAL_STEP, re_step);
        cfg_write(REG_IMAG_STEP, im_step);
        cfg_write(REG_MAX_ITER, {16'd0, limit});
    endtask

    // one pixel transfer; valid stays high unless a gap is drawn
    task automatic send_pixel(input logic [11:0] row, input logic [11:0] col);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    // stop sending and wait for every predicted pixel to come back
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // a new plane then a run of random pixels, with a full drain halfway
    task automatic random_block(input int count, input bit wild);
        logic signed [31:0] left, lower, re_step, im_step;
        logic [15:0]        limit;
        drain_pixels();
        if (wild) begin
            // any bit pattern in the plane registers
            left    = $urandom;
            lower   = $urandom;
            re_step = $urandom;
            im_step = $urandom;
            limit   = 16'($urandom_range(300, 1));
            cfg_write(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), $urandom);
        end else begin
            // window around the set, up to about 2.5 units across the full index range
            left    = int'($urandom_range(939524096)) - 671088640;
            lower   = int'($urandom_range(671088640)) - 335544320;
            re_step = int'($urandom_range(327680)) - 163840;
            im_step = int'($urandom_range(327680)) - 163840;
            limit   = 16'($urandom_range(256, 8));
        end
        set_plane(left, lower, re_step, im_step, limit);
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) begin
                drain_pixels();
            end
            send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)));
        end
    endtask

    initial begin : stimulus
        tx_idle_pct = 37;
        rx_idle_pct <= 61;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset plane puts every pixel at -2-2i
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // 3/64 grid over the main cardioid and the real axis
        drain_pixels();
        set_plane(-2 * Q_ONE, -(3 * Q_ONE) / 2, (3 * Q_ONE) / 64, (3 * Q_ONE) / 64, 16'd64);
        send_pixel(12'd32, 12'd42);
        send_pixel(12'd32, 12'd0);
        send_pixel(12'd32, 12'd16);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd45, 12'd40);
        send_pixel(12'd50, 12'd48);
        send_pixel(12'd32, 12'd49);
        send_pixel(12'd40, 12'd38);

        // zero limit: count zero, black
        drain_pixels();
        cfg_write(REG_MAX_ITER, 32'd0);
        send_pixel(12'd20, 12'd20);

        // single iteration, one escaping and one not
        drain_pixels();
        cfg_write(REG_MAX_ITER, 32'd1);
        send_pixel(12'd32, 12'd0);
        send_pixel(12'd32, 12'd42);

        // saturating coordinate sums both ways
        drain_pixels();
        set_plane(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'd50);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        drain_pixels();
        set_plane(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'd50);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);

        // writes to unused indexes must leave the plane alone
        drain_pixels();
        cfg_write(REG_SPARE_LO, $urandom);
        cfg_write(REG_SPARE_HI, $urandom);
        send_pixel(12'd100, 12'd200);

        // origin never escapes, widest limit
        drain_pixels();
        set_plane(32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'hffff);
        send_pixel(12'd4095, 12'd0);

        random_block(12, 1'b0);
        random_block(12, 1'b0);

        // sender busy, receiver mostly ready
        tx_idle_pct = 61;
        rx_idle_pct <= 37;
        random_block(14, 1'b0);
        random_block(14, 1'b1);

        // full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        random_block(14, 1'b0);
        random_block(14, 1'b0);

        drain_pixels();
        repeat (16) @(posedge i_clk);

        $display("%0d pixels sent over %0d register writes, %0d results compared",
                 pixels_sent, reg_writes, checked);
        $display("orbits up to %0d iterations, planes from defaults to saturated extremes",
                 longest);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mep_pkg.sv
rtl/core/mep_fifo.sv
rtl/core/mep_front.sv
rtl/core/mep_back.sv
rtl/core/mandelbrot_escape_pixel.sv
verif/mandelbrot_escape_pixel_chk.sv
verif/mandelbrot_escape_pixel_tb.sv
